// ===== rtl/sgcr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgcr_pkg
// Shared types, codes and defaults of the screen grid cursor router.
// ----------------------------------------------------------------------------
package sgcr_pkg;

    localparam int MAX_SCREENS_DEF = 16;
    localparam int GRID_DIM_DEF    = 16;

    localparam int NUM_W = 31;
    localparam int DEN_W = 16;
    localparam int QUO_W = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_HIT    = 2'd2;
    localparam logic [1:0] OP_MAP    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_TAKEN    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_NO_NB    = 3'd5;
    localparam logic [2:0] ST_NO_EDGE  = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_TOP    = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    typedef struct packed {
        logic [7:0]  owner;
        logic [3:0]  scr;
        logic [3:0]  cx;
        logic [3:0]  cy;
        logic [14:0] w;
        logic [14:0] h;
    } tbl_entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CELL,
        S_DST,
        S_MUL,
        S_DSTART,
        S_DIV
    } state_t;

endpackage

// ===== rtl/sgcr_ram.sv =====
// ----------------------------------------------------------------------------
// sgcr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sgcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sgcr_div.sv =====
// ----------------------------------------------------------------------------
// sgcr_div
// Restoring divider, one quotient bit per cycle, for quotients below 2**16.
// ----------------------------------------------------------------------------
module sgcr_div
    import sgcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] shf_reg, shf_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, shf_reg[QUO_W-1]};
        if (start)
        begin
            rem_next = {1'b0, num[NUM_W-1:QUO_W]};
            shf_next = num[QUO_W-1:0];
            quo_next = '0;
            cnt_next = 5'(QUO_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = DEN_W'(trial - {1'b0, den});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            shf_next = {shf_reg[QUO_W-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/screen_grid_cursor_router.sv =====
// ----------------------------------------------------------------------------
// screen_grid_cursor_router
// Screen table on a grid with add, remove-owner, edge hit and edge crossing.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; each command
// gives one result, shown for one cycle with done high, and the receiver
// cannot stall it. After reset busy stays high while the cell map is cleared.
// Every command except a bad-size add walks the screen table one entry per
// cycle; a map that crosses to a neighbour adds two memory reads and, when
// both extents exceed one, a multiply and a 16-step divider.
// ----------------------------------------------------------------------------
module screen_grid_cursor_router
    import sgcr_pkg::*;
#(
    parameter int MAX_SCREENS = MAX_SCREENS_DEF,
    parameter int GRID_DIM    = GRID_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  owner_id,
    input  logic [3:0]  screen_num,
    input  logic [3:0]  cell_x,
    input  logic [3:0]  cell_y,
    input  logic [14:0] width,
    input  logic [14:0] height,
    input  logic [1:0]  edge_req,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    output logic        done,
    output logic [2:0]  status,
    output logic [1:0]  edge_out,
    output logic [7:0]  target_owner,
    output logic [3:0]  target_screen,
    output logic [14:0] out_x,
    output logic [14:0] out_y
);

    localparam int IDX_W   = $clog2(MAX_SCREENS);
    localparam int CNT_W   = $clog2(MAX_SCREENS + 1);
    localparam int CELLS   = GRID_DIM * GRID_DIM;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int CELL_DW = IDX_W + 1;
    localparam int TBL_DW  = $bits(tbl_entry_t);
    localparam logic [6:0] GRID_LIM = 7'(GRID_DIM);

    function automatic logic [CELL_W-1:0] cell_index(input logic [6:0] x, input logic [6:0] y);
        logic [13:0] a;
        a = 14'(y) * 14'(GRID_DIM) + 14'(x);
        return a[CELL_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               found_reg, found_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [MAX_SCREENS-1:0] valid_reg, valid_next;
    logic [CELL_W-1:0]  clr_reg, clr_next;
    logic               done_reg, done_next;

    logic [1:0]  op_reg, op_next;
    logic [7:0]  owner_reg, owner_next;
    logic [3:0]  scr_reg, scr_next;
    logic [3:0]  cx_reg, cx_next;
    logic [3:0]  cy_reg, cy_next;
    logic [14:0] w_reg, w_next;
    logic [14:0] h_reg, h_next;
    logic [1:0]  edge_reg, edge_next;
    logic [15:0] px_reg, px_next;
    logic [15:0] py_reg, py_next;
    tbl_entry_t  ent_reg, ent_next;
    logic [14:0] s_reg, s_next;
    logic [14:0] t_reg, t_next;
    logic [14:0] cc_reg, cc_next;
    logic [29:0] prod_reg, prod_next;

    logic [2:0]  status_reg, status_next;
    logic [1:0]  edge_out_reg, edge_out_next;
    logic [7:0]  tgt_owner_reg, tgt_owner_next;
    logic [3:0]  tgt_scr_reg, tgt_scr_next;
    logic [14:0] ox_reg, ox_next;
    logic [14:0] oy_reg, oy_next;

    logic               tbl_we, tbl_re;
    logic [IDX_W-1:0]   tbl_waddr, tbl_raddr;
    logic [TBL_DW-1:0]  tbl_wdata, tbl_rdata;
    tbl_entry_t         tbl_ent;

    logic               cell_we, cell_re;
    logic [CELL_W-1:0]  cell_waddr, cell_raddr;
    logic [CELL_DW-1:0] cell_wdata, cell_rdata;

    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [QUO_W-1:0]   div_quo;

    logic               lr;
    logic [6:0]         nx, ny;
    logic [16:0]        pxs, pys, wm1, hm1;
    logic [14:0]        src_ext, dst_ext;
    logic [15:0]        coord;
    logic [14:0]        qclamp;

    sgcr_ram #(.WIDTH(TBL_DW), .DEPTH(MAX_SCREENS)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sgcr_ram #(.WIDTH(CELL_DW), .DEPTH(CELLS)) u_cell (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    sgcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign tbl_ent = tbl_entry_t'(tbl_rdata);
    assign div_num = {prod_reg, 1'b0} + NUM_W'(s_reg);
    assign div_den = {s_reg, 1'b0};
    assign lr      = (edge_reg == EDGE_LEFT) || (edge_reg == EDGE_RIGHT);
    assign pxs     = {px_reg[15], px_reg};
    assign pys     = {py_reg[15], py_reg};
    assign wm1     = {2'b00, ent_reg.w} - 17'd1;
    assign hm1     = {2'b00, ent_reg.h} - 17'd1;
    assign qclamp  = (div_quo > {1'b0, t_reg}) ? t_reg : div_quo[14:0];

    always_comb
    begin
        nx = {3'b000, ent_reg.cx};
        ny = {3'b000, ent_reg.cy};
        unique case (edge_reg)
            EDGE_LEFT:   nx = {3'b000, ent_reg.cx} - 7'd1;
            EDGE_RIGHT:  nx = {3'b000, ent_reg.cx} + 7'd1;
            EDGE_TOP:    ny = {3'b000, ent_reg.cy} - 7'd1;
            EDGE_BOTTOM: ny = {3'b000, ent_reg.cy} + 7'd1;
            default:     nx = {3'b000, ent_reg.cx};
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        clr_next        = clr_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        owner_next      = owner_reg;
        scr_next        = scr_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        edge_next       = edge_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        ent_next        = ent_reg;
        s_next          = s_reg;
        t_next          = t_reg;
        cc_next         = cc_reg;
        prod_next       = prod_reg;
        status_next     = status_reg;
        edge_out_next   = edge_out_reg;
        tgt_owner_next  = tgt_owner_reg;
        tgt_scr_next    = tgt_scr_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = free_idx_reg;
        tbl_wdata       = {owner_reg, scr_reg, cx_reg, cy_reg, w_reg, h_reg};
        tbl_re          = 1'b0;
        tbl_raddr       = scan_reg[IDX_W-1:0];
        cell_we         = 1'b0;
        cell_waddr      = clr_reg;
        cell_wdata      = '0;
        cell_re         = 1'b0;
        cell_raddr      = cell_index({3'b000, cell_x}, {3'b000, cell_y});
        div_start       = 1'b0;
        src_ext         = lr ? ent_reg.h : ent_reg.w;
        dst_ext         = lr ? tbl_ent.h : tbl_ent.w;
        coord           = lr ? py_reg : px_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cell_we  = 1'b1;
                clr_next = clr_reg + CELL_W'(1);
                if (clr_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = op;
                    owner_next      = owner_id;
                    scr_next        = screen_num;
                    cx_next         = cell_x;
                    cy_next         = cell_y;
                    w_next          = width;
                    h_next          = height;
                    edge_next       = edge_req;
                    px_next         = point_x;
                    py_next         = point_y;
                    scan_next       = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    status_next     = ST_OK;
                    edge_out_next   = EDGE_LEFT;
                    tgt_owner_next  = '0;
                    tgt_scr_next    = '0;
                    ox_next         = '0;
                    oy_next         = '0;
                    if ((op == OP_ADD) && ((width == '0) || (height == '0)))
                    begin
                        status_next = ST_BAD_SIZE;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cell_re    = (op == OP_ADD);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_reg < CNT_W'(MAX_SCREENS))
                begin
                    tbl_re       = 1'b1;
                    scan_next    = scan_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg] && (tbl_ent.owner == owner_reg))
                    begin
                        if (op_reg == OP_REMOVE)
                        begin
                            valid_next[chk_idx_reg] = 1'b0;
                            cell_we    = 1'b1;
                            cell_waddr = cell_index({3'b000, tbl_ent.cx},
                                                    {3'b000, tbl_ent.cy});
                        end
                        else if (tbl_ent.scr == scr_reg)
                        begin
                            found_next = 1'b1;
                            ent_next   = tbl_ent;
                        end
                    end
                    if (!valid_reg[chk_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                else if (scan_reg == CNT_W'(MAX_SCREENS))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (found_reg)
                            begin
                                status_next = ST_DUP;
                            end
                            else if (({3'b000, cx_reg} >= GRID_LIM) ||
                                     ({3'b000, cy_reg} >= GRID_LIM) ||
                                     cell_rdata[IDX_W])
                            begin
                                status_next = ST_TAKEN;
                            end
                            else if (!free_found_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                tbl_we     = 1'b1;
                                cell_we    = 1'b1;
                                cell_waddr = cell_index({3'b000, cx_reg}, {3'b000, cy_reg});
                                cell_wdata = {1'b1, free_idx_reg};
                                valid_next[free_idx_reg] = 1'b1;
                            end
                        end
                        OP_HIT:
                        begin
                            if (!found_reg)
                            begin
                                status_next = ST_UNKNOWN;
                            end
                            else if ($signed(pxs) <= 17'sd0)
                            begin
                                edge_out_next = EDGE_LEFT;
                            end
                            else if ($signed(pxs) >= $signed(wm1))
                            begin
                                edge_out_next = EDGE_RIGHT;
                            end
                            else if ($signed(pys) <= 17'sd0)
                            begin
                                edge_out_next = EDGE_TOP;
                            end
                            else if ($signed(pys) >= $signed(hm1))
                            begin
                                edge_out_next = EDGE_BOTTOM;
                            end
                            else
                            begin
                                status_next = ST_NO_EDGE;
                            end
                        end
                        OP_MAP:
                        begin
                            if (!found_reg)
                            begin
                                status_next = ST_UNKNOWN;
                            end
                            else if ((nx >= GRID_LIM) || (ny >= GRID_LIM))
                            begin
                                status_next = ST_NO_NB;
                            end
                            else
                            begin
                                cell_re    = 1'b1;
                                cell_raddr = cell_index(nx, ny);
                                done_next  = 1'b0;
                                state_next = S_CELL;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_CELL:
            begin
                if (!cell_rdata[IDX_W] ||
                    (CNT_W'(cell_rdata[IDX_W-1:0]) >= CNT_W'(MAX_SCREENS)) ||
                    !valid_reg[cell_rdata[IDX_W-1:0]])
                begin
                    status_next = ST_NO_NB;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    tbl_re     = 1'b1;
                    tbl_raddr  = cell_rdata[IDX_W-1:0];
                    state_next = S_DST;
                end
            end

            S_DST:
            begin
                tgt_owner_next = tbl_ent.owner;
                tgt_scr_next   = tbl_ent.scr;
                case (edge_reg)
                    EDGE_LEFT:  ox_next = tbl_ent.w - 15'd1;
                    EDGE_TOP:   oy_next = tbl_ent.h - 15'd1;
                    default:    ox_next = ox_reg;
                endcase
                s_next = src_ext - 15'd1;
                t_next = dst_ext - 15'd1;
                if (coord[15])
                begin
                    cc_next = '0;
                end
                else if (coord[14:0] > (src_ext - 15'd1))
                begin
                    cc_next = src_ext - 15'd1;
                end
                else
                begin
                    cc_next = coord[14:0];
                end
                if ((src_ext <= 15'd1) || (dst_ext <= 15'd1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = cc_reg * t_reg;
                state_next = S_DSTART;
            end

            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (lr)
                    begin
                        oy_next = qclamp;
                    end
                    else
                    begin
                        ox_next = qclamp;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            chk_vld_reg    <= 1'b0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            chk_vld_reg    <= chk_vld_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        free_idx_reg  <= free_idx_next;
        op_reg        <= op_next;
        owner_reg     <= owner_next;
        scr_reg       <= scr_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        edge_reg      <= edge_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        ent_reg       <= ent_next;
        s_reg         <= s_next;
        t_reg         <= t_next;
        cc_reg        <= cc_next;
        prod_reg      <= prod_next;
        status_reg    <= status_next;
        edge_out_reg  <= edge_out_next;
        tgt_owner_reg <= tgt_owner_next;
        tgt_scr_reg   <= tgt_scr_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign edge_out      = edge_out_reg;
    assign target_owner  = tgt_owner_reg;
    assign target_screen = tgt_scr_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;

endmodule
